[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/derl_pkg.sv]
// Types and constants of the event ring log.
`default_nettype none

package derl_pkg;

   localparam int ID_W        = 64;
   localparam int LEVEL_W     = 6;
   localparam int SLOT_W      = 8;
   localparam int OUT_COUNT_W = 16;
   localparam int FILL_W      = 9;
   localparam int OP_W        = 2;
   localparam int OUTCOME_W   = 3;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 104;

   localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(200);

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_FLUSH = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [OUTCOME_W-1:0] {
      RES_INSERTED = 3'd0,
      RES_MERGED   = 3'd1,
      RES_DROPPED  = 3'd2,
      RES_FLUSHED  = 3'd3,
      RES_READ     = 3'd4
   } res_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RDWAIT,
      ST_RESP
   } st_type;

endpackage

`default_nettype wire

[rtl/core/derl_slot_store.sv]
// Slot memory of the ring log: one write port, one registered read port.
`default_nettype none

module derl_slot_store #(
   parameter int DEPTH      = 256,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic                         wr_valid,
   input  wire logic [derl_pkg::ID_W-1:0]    wr_id,
   input  wire logic [derl_pkg::LEVEL_W-1:0] wr_level,
   input  wire logic [COUNT_BITS-1:0]        wr_count,
   output logic                              rd_valid,
   output logic [derl_pkg::ID_W-1:0]         rd_id,
   output logic [derl_pkg::LEVEL_W-1:0]      rd_level,
   output logic [COUNT_BITS-1:0]             rd_count
);
   import derl_pkg::*;

   localparam int WORD_W = 1 + ID_W + LEVEL_W + COUNT_BITS;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_valid, wr_id, wr_level, wr_count};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   assign {rd_valid, rd_id, rd_level, rd_count} = rd_word_ff;

endmodule

`default_nettype wire

[rtl/core/dedup_event_ring_log.sv]
// Adds compare one slot per cycle through the slot memory's single read port,
// stopping at the first match; a flush clears one slot per cycle.
// One request at a time: the next request is taken once the result sits in the
// output register. Reset is synchronous; after it a clearing pass over all DEPTH
// slots runs with req_tready low, and configuration writes are taken throughout.
`default_nettype none

module dedup_event_ring_log #(
   parameter int DEPTH      = 256,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // message_id[63:0], level_mask[69:64], slot_index[77:70], zero pad [79:78]
   input  wire logic [derl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  wire logic [derl_pkg::OP_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hit_slot[7:0], entry_valid[8], entry_id[72:9], entry_level[78:73],
   // entry_count[94:79], fill_count[103:95]
   output logic [derl_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // outcome[2:0]
   output logic [derl_pkg::OUTCOME_W-1:0]        rsp_tuser,
   input  wire logic                             csr_wen,
   input  wire logic [derl_pkg::FILL_W-1:0]      csr_wdata
);
   import derl_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = $clog2(DEPTH + 1) + FILL_W;

   st_type                  state_ff, state_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [FILL_W-1:0]       filled_ff, filled_in;
   logic [FILL_W-1:0]       cap_ff, cap_in;
   logic [AW-1:0]           scan_addr_ff, scan_addr_in;
   logic [CW-1:0]           scan_cnt_ff, scan_cnt_in;
   logic                    chk_ff, chk_in;
   logic [AW-1:0]           chk_addr_ff, chk_addr_in;
   logic                    flush_ff, flush_in;

   res_type                 res_outcome_ff, res_outcome_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic                    res_valid_ff, res_valid_in;
   logic [ID_W-1:0]         res_id_ff, res_id_in;
   logic [LEVEL_W-1:0]      res_level_ff, res_level_in;
   logic [COUNT_BITS-1:0]   res_count_ff, res_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [OUTCOME_W-1:0]    rsp_user_ff, rsp_user_in;

   // request fields
   logic [ID_W-1:0]         req_id;
   logic [LEVEL_W-1:0]      req_level;
   logic [SLOT_W-1:0]       req_slot;
   logic [AW+SLOT_W-1:0]    req_slot_wide;
   logic [AW-1:0]           req_addr;
   logic                    req_in_range;
   logic                    accept;

   // memory ports
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic                    wr_valid;
   logic [ID_W-1:0]         wr_id;
   logic [LEVEL_W-1:0]      wr_level;
   logic [COUNT_BITS-1:0]   wr_count;
   logic                    rd_valid;
   logic [ID_W-1:0]         rd_id;
   logic [LEVEL_W-1:0]      rd_level;
   logic [COUNT_BITS-1:0]   rd_count;

   // scan and ring arithmetic
   logic                    scan_issue;
   logic                    scan_hit;
   logic                    scan_miss;
   logic                    clear_done;
   logic [COUNT_BITS-1:0]   sat_count;
   logic [CMP_W-1:0]        cap_wide;
   logic [CMP_W-1:0]        eff_cap;
   logic [CMP_W-1:0]        wp_plus;
   logic [AW-1:0]           wp_next;
   logic [FILL_W-1:0]       filled_next;
   logic [AW+SLOT_W-1:0]    chk_slot_wide;
   logic [AW+SLOT_W-1:0]    wp_slot_wide;
   logic                    out_free;
   logic [COUNT_BITS+OUT_COUNT_W-1:0] res_count_wide;
   logic [ID_W-1:0]         out_id;
   logic [LEVEL_W-1:0]      out_level;
   logic [OUT_COUNT_W-1:0]  out_count;

   assign req_id        = req_tdata[ID_W-1:0];
   assign req_level     = req_tdata[ID_W+LEVEL_W-1:ID_W];
   assign req_slot      = req_tdata[ID_W+LEVEL_W+SLOT_W-1:ID_W+LEVEL_W];
   assign req_slot_wide = {{AW{1'b0}}, req_slot};
   assign req_addr      = req_slot_wide[AW-1:0];
   assign req_in_range  = CMP_W'(req_slot) < CMP_W'(DEPTH);
   assign accept        = req_tvalid && req_tready;

   assign cap_wide = CMP_W'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_wide > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_wide;
      end
   end

   assign wp_plus     = CMP_W'(wp_ff) + CMP_W'(1);
   assign wp_next     = (wp_plus >= eff_cap) ? '0 : wp_plus[AW-1:0];
   assign filled_next = (CMP_W'(filled_ff) < eff_cap) ? filled_ff + FILL_W'(1) : filled_ff;

   assign scan_issue = (state_ff == ST_SCAN) && (scan_cnt_ff < CW'(DEPTH));
   assign scan_hit   = (state_ff == ST_SCAN) && chk_ff && rd_valid && (rd_id == res_id_ff);
   assign scan_miss  = (state_ff == ST_SCAN) && !chk_ff && (scan_cnt_ff == CW'(DEPTH));
   assign clear_done = (scan_addr_ff == AW'(DEPTH - 1));
   assign sat_count  = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count
                                                        : rd_count + COUNT_BITS'(1);

   assign chk_slot_wide = {{SLOT_W{1'b0}}, chk_addr_ff};
   assign wp_slot_wide  = {{SLOT_W{1'b0}}, wp_ff};
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = flush_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (op_type'(req_tuser))
                  OP_ADD:   state_in = (req_level != '0) ? ST_SCAN : ST_RESP;
                  OP_FLUSH: state_in = ST_CLEAR;
                  OP_READ:  state_in = ST_RDWAIT;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = ST_RESP;
            end
         end
         ST_RDWAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory controls
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rd_en      = (state_ff == ST_IDLE) || scan_issue;
      rd_addr    = (state_ff == ST_SCAN) ? scan_addr_ff : req_addr;
      wr_en      = 1'b0;
      wr_addr    = scan_addr_ff;
      wr_valid   = 1'b0;
      wr_id      = res_id_ff;
      wr_level   = res_level_ff;
      wr_count   = COUNT_BITS'(1);
      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_id    = '0;
            wr_level = '0;
            wr_count = '0;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               wr_en    = 1'b1;
               wr_addr  = chk_addr_ff;
               wr_valid = 1'b1;
               wr_level = rd_level;
               wr_count = sat_count;
            end else if (scan_miss) begin
               wr_en    = 1'b1;
               wr_addr  = wp_ff;
               wr_valid = 1'b1;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      wp_in          = wp_ff;
      filled_in      = filled_ff;
      cap_in         = csr_wen ? csr_wdata : cap_ff;
      scan_addr_in   = scan_addr_ff;
      scan_cnt_in    = scan_cnt_ff;
      chk_in         = 1'b0;
      chk_addr_in    = scan_addr_ff;
      flush_in       = flush_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      res_valid_in   = res_valid_ff;
      res_id_in      = res_id_ff;
      res_level_in   = res_level_ff;
      res_count_in   = res_count_ff;
      case (state_ff)
         ST_CLEAR: begin
            scan_addr_in = clear_done ? '0 : scan_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               res_id_in      = req_id;
               res_level_in   = req_level;
               res_slot_in    = '0;
               res_valid_in   = 1'b0;
               res_count_in   = '0;
               res_outcome_in = RES_DROPPED;
               case (op_type'(req_tuser))
                  OP_ADD: begin
                     scan_addr_in = wp_ff;
                     scan_cnt_in  = '0;
                  end
                  OP_FLUSH: begin
                     wp_in          = '0;
                     filled_in      = '0;
                     scan_addr_in   = '0;
                     flush_in       = 1'b1;
                     res_outcome_in = RES_FLUSHED;
                  end
                  OP_READ: begin
                     res_outcome_in = RES_READ;
                     res_slot_in    = req_slot;
                     res_valid_in   = req_in_range;
                  end
                  default: begin
                     res_outcome_in = RES_DROPPED;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               scan_addr_in = (scan_addr_ff == AW'(DEPTH - 1)) ? '0
                                                                : scan_addr_ff + AW'(1);
               scan_cnt_in  = scan_cnt_ff + CW'(1);
               chk_in       = 1'b1;
            end
            if (scan_hit) begin
               res_outcome_in = RES_MERGED;
               res_slot_in    = chk_slot_wide[SLOT_W-1:0];
               res_valid_in   = 1'b1;
               res_level_in   = rd_level;
               res_count_in   = sat_count;
            end else if (scan_miss) begin
               res_outcome_in = RES_INSERTED;
               res_slot_in    = wp_slot_wide[SLOT_W-1:0];
               res_valid_in   = 1'b1;
               res_count_in   = COUNT_BITS'(1);
               wp_in          = wp_next;
               filled_in      = filled_next;
            end
         end
         ST_RDWAIT: begin
            res_valid_in = res_valid_ff && rd_valid;
            res_id_in    = rd_id;
            res_level_in = rd_level;
            res_count_in = rd_count;
         end
         ST_RESP: begin
            flush_in = 1'b0;
         end
         default: begin
            flush_in = 1'b0;
         end
      endcase
   end

   // output register: zero the entry fields of results without a record
   assign res_count_wide = {{OUT_COUNT_W{1'b0}}, res_count_ff};
   assign out_id    = res_valid_ff ? res_id_ff : '0;
   assign out_level = res_valid_ff ? res_level_ff : '0;
   assign out_count = res_valid_ff ? res_count_wide[OUT_COUNT_W-1:0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESP) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {filled_ff, out_count, out_level, out_id, res_valid_ff, res_slot_ff};
         rsp_user_in  = res_outcome_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         filled_ff    <= '0;
         cap_ff       <= CAP_RESET;
         scan_addr_ff <= '0;
         scan_cnt_ff  <= '0;
         chk_ff       <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         filled_ff    <= filled_in;
         cap_ff       <= cap_in;
         scan_addr_ff <= scan_addr_in;
         scan_cnt_ff  <= scan_cnt_in;
         chk_ff       <= chk_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff    <= chk_addr_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      res_valid_ff   <= res_valid_in;
      res_id_ff      <= res_id_in;
      res_level_ff   <= res_level_in;
      res_count_ff   <= res_count_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   derl_slot_store #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_valid (wr_valid),
      .wr_id    (wr_id),
      .wr_level (wr_level),
      .wr_count (wr_count),
      .rd_valid (rd_valid),
      .rd_id    (rd_id),
      .rd_level (rd_level),
      .rd_count (rd_count)
   );

endmodule

`default_nettype wire

[rtl/core/derl_checker.sv]
// Port-level assertions for the event ring log, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module derl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [derl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [derl_pkg::OUTCOME_W-1:0]   rsp_tuser
);
   import derl_pkg::*;

   // only one request in flight
   `ASSERT_NEXT(a_one_request, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed under stall")

   // insert and merge always report a live record with a nonzero count and fill
   `ASSERT_IMPLY(a_write_entry, clock, reset, rsp_tvalid && (rsp_tuser == RES_INSERTED || rsp_tuser == RES_MERGED), rsp_tdata[8] && (rsp_tdata[94:79] != '0) && (rsp_tdata[103:95] != '0), "bad insert or merge result")

   // flush empties the log
   `ASSERT_IMPLY(a_flush_empty, clock, reset, rsp_tvalid && (rsp_tuser == RES_FLUSHED), !rsp_tdata[8] && (rsp_tdata[103:95] == '0), "flush left a fill count")

endmodule

bind dedup_event_ring_log derl_checker u_derl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[dv/dedup_event_ring_log_checker.sv]
// Checker for the event ring log: predicts every response and compares it field by field.
`timescale 1ns / 1ps

module dedup_event_ring_log_checker
   import derl_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [OUTCOME_W-1:0]  rsp_tuser,
   input  logic                  csr_wen,
   input  logic [FILL_W-1:0]     csr_wdata,
   output int                    fail_count
);

   localparam int MAX_REPORTS = 60;

   typedef struct packed {
      logic [OUTCOME_W-1:0]   outcome;
      logic [SLOT_W-1:0]      slot;
      logic                   valid;
      logic [ID_W-1:0]        id;
      logic [LEVEL_W-1:0]     level;
      logic [OUT_COUNT_W-1:0] count;
      logic [FILL_W-1:0]      fill;
   } log_result_t;

   // shadow copy of the ring
   logic                   ring_valid [DEPTH];
   logic [ID_W-1:0]        ring_id    [DEPTH];
   logic [LEVEL_W-1:0]     ring_level [DEPTH];
   logic [OUT_COUNT_W-1:0] ring_count [DEPTH];
   int unsigned            wr_ptr;
   int unsigned            fill;
   logic [FILL_W-1:0]      capacity;

   log_result_t            expected_log_results [$];
   int                     outstanding = 0;
   int                     mismatches  = 0;

   // predictions still waiting at the end count as failures
   assign fail_count = mismatches + outstanding;

   function automatic log_result_t apply_request(input logic [OP_W-1:0]    op,
                                                 input logic [ID_W-1:0]    id,
                                                 input logic [LEVEL_W-1:0] level,
                                                 input logic [SLOT_W-1:0]  idx);
      log_result_t r;
      int          hit;
      int          w;
      int unsigned cap;
      r         = '0;
      r.outcome = RES_DROPPED;
      r.fill    = FILL_W'(fill);
      cap       = (capacity == '0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
      case (op)
         OP_ADD: begin
            if (level != '0) begin
               hit = -1;
               // ring order: from the write pointer to the top, then wrap
               for (int k = 0; k < DEPTH && hit < 0; k++) begin
                  w = (wr_ptr + k) % DEPTH;
                  if (ring_valid[w] && ring_id[w] == id) hit = w;
               end
               if (hit >= 0) begin
                  if (ring_count[hit] != '1) ring_count[hit] = ring_count[hit] + 1'b1;
                  r.outcome = RES_MERGED;
                  r.slot    = SLOT_W'(hit);
                  r.valid   = 1'b1;
                  r.id      = ring_id[hit];
                  r.level   = ring_level[hit];
                  r.count   = ring_count[hit];
               end else begin
                  w             = wr_ptr;
                  ring_valid[w] = 1'b1;
                  ring_id[w]    = id;
                  ring_level[w] = level;
                  ring_count[w] = OUT_COUNT_W'(1);
                  wr_ptr        = (w + 1 >= cap) ? 0 : w + 1;
                  if (fill < cap) fill++;
                  r.outcome = RES_INSERTED;
                  r.slot    = SLOT_W'(w);
                  r.valid   = 1'b1;
                  r.id      = id;
                  r.level   = level;
                  r.count   = OUT_COUNT_W'(1);
                  r.fill    = FILL_W'(fill);
               end
            end
         end
         OP_FLUSH: begin
            for (int k = 0; k < DEPTH; k++) ring_valid[k] = 1'b0;
            wr_ptr    = 0;
            fill      = 0;
            r.outcome = RES_FLUSHED;
            r.fill    = '0;
         end
         OP_READ: begin
            r.outcome = RES_READ;
            r.slot    = idx;
            if (ring_valid[idx]) begin
               r.valid = 1'b1;
               r.id    = ring_id[idx];
               r.level = ring_level[idx];
               r.count = ring_count[idx];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
      if (want !== got) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_response();
      log_result_t want;
      log_result_t got;
      got.outcome = rsp_tuser;
      got.slot    = rsp_tdata[7:0];
      got.valid   = rsp_tdata[8];
      got.id      = rsp_tdata[72:9];
      got.level   = rsp_tdata[78:73];
      got.count   = rsp_tdata[94:79];
      got.fill    = rsp_tdata[103:95];
      if (expected_log_results.size() == 0) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: response with no request outstanding, expected none, actual outcome %0d",
                     $time, got.outcome);
         mismatches++;
      end else begin
         want = expected_log_results.pop_front();
         outstanding--;
         check_field("outcome", ID_W'(want.outcome), ID_W'(got.outcome));
         check_field("hit_slot", ID_W'(want.slot), ID_W'(got.slot));
         check_field("entry_valid", ID_W'(want.valid), ID_W'(got.valid));
         check_field("entry_id", want.id, got.id);
         check_field("entry_level", ID_W'(want.level), ID_W'(got.level));
         check_field("entry_count", ID_W'(want.count), ID_W'(got.count));
         check_field("fill_count", ID_W'(want.fill), ID_W'(got.fill));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            ring_valid[k] = 1'b0;
            ring_id[k]    = '0;
            ring_level[k] = '0;
            ring_count[k] = '0;
         end
         wr_ptr   = 0;
         fill     = 0;
         capacity = CAP_RESET;
         expected_log_results.delete();
         outstanding = 0;
      end else begin
         if (csr_wen) capacity = csr_wdata;
         if (req_tvalid && req_tready) begin
            expected_log_results.push_back(apply_request(req_tuser, req_tdata[63:0],
                                                         req_tdata[69:64], req_tdata[77:70]));
            outstanding++;
         end
         if (rsp_tvalid && rsp_tready) compare_response();
      end
   end

endmodule

[dv/dedup_event_ring_log_tb.sv]
// Testbench top for the event ring log: drives requests and capacity writes, gives the verdict.
`timescale 1ns / 1ps

module dedup_event_ring_log_tb;
   import derl_pkg::*;

   localparam int              DEPTH       = 256;
   localparam int              POOL_SIZE   = 24;
   localparam int              CHUNK_ITEMS = 92;
   localparam int              LONG_HOLD   = 400;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam logic [ID_W-1:0] ID_ONES     = '1;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [OUTCOME_W-1:0]  rsp_tuser;
   logic                  csr_wen    = 1'b0;
   logic [FILL_W-1:0]     csr_wdata  = '0;
   int                    fail_count;

   int                    send_idle_pct = 14;
   int                    recv_idle_pct = 53;
   int                    hold_requests = 0;
   int                    hold_seen     = 0;
   int                    hold_left     = 0;
   int                    sent_count    = 0;
   int                    recv_count    = 0;
   int                    add_count     = 0;
   int                    read_count    = 0;
   int                    flush_count   = 0;
   int                    unused_count  = 0;
   int                    cap_writes    = 0;
   logic [FILL_W-1:0]     cap_setting   = CAP_RESET;
   logic [ID_W-1:0]       id_pool [POOL_SIZE];
   logic [FILL_W-1:0]     chunk_caps [9] = '{9'd7, 9'd256, 9'd0, 9'd511, 9'd3,
                                             9'd200, 9'd1, 9'd64, 9'd255};

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   dedup_event_ring_log #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   dedup_event_ring_log_checker #(
      .DEPTH (DEPTH)
   ) log_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count)
   );

   // response side: random back-pressure, plus a long hold when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) recv_count <= recv_count + 1;
   end

   task automatic send_request(input logic [OP_W-1:0]    op,
                               input logic [ID_W-1:0]    id,
                               input logic [LEVEL_W-1:0] level,
                               input logic [SLOT_W-1:0]  idx);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, idx, level, id};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      case (op)
         OP_ADD:   add_count++;
         OP_READ:  read_count++;
         OP_FLUSH: flush_count++;
         default:  unused_count++;
      endcase
   endtask

   // hold requests back until every response has been taken
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (recv_count != sent_count) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [FILL_W-1:0] value);
      wait_for_responses();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen     <= 1'b0;
      cap_setting  = value;
      cap_writes++;
   endtask

   task automatic send_random_request();
      int                  pick;
      int                  span;
      logic [OP_W-1:0]     op;
      logic [ID_W-1:0]     id;
      logic [LEVEL_W-1:0]  level;
      logic [SLOT_W-1:0]   idx;
      pick = $urandom_range(99);
      if (pick < 62)      op = OP_ADD;
      else if (pick < 89) op = OP_READ;
      else if (pick < 93) op = OP_FLUSH;
      else                op = OP_UNUSED;
      // mostly reuse known ids so adds merge as well as insert
      if ($urandom_range(9) < 7) id = id_pool[$urandom_range(POOL_SIZE - 1)];
      else                       id = {$urandom(), $urandom()};
      pick = $urandom_range(9);
      if (pick == 0)      level = '0;
      else if (pick == 1) level = LEVEL_W'($urandom());
      else                level = LEVEL_W'(1) << $urandom_range(LEVEL_W - 1);
      span = (cap_setting == '0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
      if ($urandom_range(9) < 7) idx = SLOT_W'($urandom_range(span - 1));
      else                       idx = SLOT_W'($urandom());
      send_request(op, id, level, idx);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty ring, insert, merge, drop, unused code, reads and flush
      send_request(OP_READ, '0, '0, 8'd0);
      send_request(OP_ADD, '0, 6'h01, 8'd0);
      send_request(OP_ADD, ID_ONES, 6'h20, 8'hFF);
      send_request(OP_ADD, '0, 6'h3F, 8'd0);
      send_request(OP_ADD, 64'hA5A5_5A5A_F00D_0001, '0, 8'd0);
      send_request(OP_UNUSED, ID_ONES, 6'h3F, 8'hFF);
      send_request(OP_READ, '0, '0, 8'd0);
      send_request(OP_READ, ID_ONES, 6'h3F, 8'd1);
      send_request(OP_READ, '0, '0, 8'hFF);
      send_request(OP_FLUSH, '0, '0, 8'd0);
      send_request(OP_READ, '0, '0, 8'd0);
      send_request(OP_ADD, '0, 6'h02, 8'd0);

      // lower the capacity below the write pointer and the fill count
      write_capacity(9'd256);
      for (int k = 1; k <= 5; k++) send_request(OP_ADD, ID_W'(k), 6'h04, 8'd0);
      write_capacity(9'd3);
      send_request(OP_ADD, 64'h77, 6'h08, 8'd0);
      send_request(OP_ADD, 64'h78, 6'h10, 8'd0);
      send_request(OP_ADD, 64'h77, 6'h01, 8'd0);
      send_request(OP_READ, '0, '0, 8'd6);
      send_request(OP_FLUSH, '0, '0, 8'd0);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 14 : ((mode == 1) ? 53 : 0);
         recv_idle_pct = (mode == 0) ? 53 : ((mode == 1) ? 14 : 0);
         for (int c = 0; c < 3; c++) begin
            write_capacity(chunk_caps[mode * 3 + c]);
            for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = {$urandom(), $urandom()};
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
               // stall the response side long enough to back up requests, or drain responses
               if (mode == 0 && c == 1 && n == 30) hold_requests++;
               if (mode == 1 && c == 0 && n == 40) wait_for_responses();
               send_random_request();
            end
         end
      end

      wait_for_responses();
      repeat (DEPTH + 8) @(posedge clock);
      $display("Covered %0d requests: %0d adds, %0d reads, %0d flushes, %0d unused codes",
               sent_count, add_count, read_count, flush_count, unused_count);
      $display("%0d capacity writes, zero and above-range included; pointer and fill left above",
               cap_writes);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Run timed out at %0t", $time);
      $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/derl_pkg.sv
rtl/core/derl_slot_store.sv
rtl/core/dedup_event_ring_log.sv
rtl/core/derl_checker.sv
dv/dedup_event_ring_log_checker.sv
dv/dedup_event_ring_log_tb.sv
